/* src/pai_pkg.sv */
package pai_pkg;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // match bits examined per scan cycle
  localparam int unsigned SCAN_W = 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_e;

  // shift control broadcast along the cell row
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

  // scanner status back to the controller
  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

  // one result beat
  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [6:0] found_index;
    logic [7:0] entry_count;
  } res_t;

endpackage

/* src/pai_req_if.sv */
interface pai_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

/* src/pai_res_if.sv */
interface pai_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       found;
  logic [6:0] found_index;
  logic [7:0] entry_count;

  modport source (output valid, status, found, found_index, entry_count, input ready);
  modport sink   (input valid, status, found, found_index, entry_count, output ready);
endinterface

/* src/pai_cell.sv */
module pai_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 8
) (
  input  logic                clk_i,
  input  pai_pkg::cell_ctrl_t ctrl_i,
  input  logic [PW-1:0]       pos_i,
  input  logic [PW-1:0]       cnt_i,
  input  logic [31:0]         val_i,
  input  logic [31:0]         left_i,
  input  logic [31:0]         right_i,
  input  logic [31:0]         key_i,
  output logic [31:0]         entry_o,
  output logic                match_o
);
  import pai_pkg::*;

  localparam logic [PW-1:0] MyIdx = PW'(IDX);

  logic [31:0] entry_q, entry_d;

  // insert: cells above the slot take the left neighbor, the slot takes the value
  // delete: cells from the slot up take the right neighbor
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (MyIdx > pos_i) begin
        entry_d = left_i;
      end else if (MyIdx == pos_i) begin
        entry_d = val_i;
      end
    end else if (ctrl_i.del) begin
      if (MyIdx >= pos_i) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // only entries below the count take part in a search
  assign match_o = (entry_q == key_i) && (MyIdx < cnt_i);

endmodule

/* src/pai_scan.sv */
module pai_scan #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned IW    = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DEPTH-1:0]    match_i,
  output pai_pkg::scan_stat_t stat_o,
  output logic [IW-1:0]       index_o
);
  import pai_pkg::*;

  localparam int unsigned NChunk = (DEPTH + SCAN_W - 1) / SCAN_W;
  localparam int unsigned KW     = (NChunk > 1) ? $clog2(NChunk) : 1;
  localparam int unsigned MW     = NChunk * SCAN_W;
  localparam int unsigned EW     = $clog2(SCAN_W);

  logic          busy_q, busy_d;
  logic [KW-1:0] chunk_q, chunk_d;
  logic [MW-1:0] vec;
  logic [SCAN_W-1:0] bits;
  logic [EW-1:0] enc;
  logic          hit, last;

  assign vec  = MW'(match_i);
  assign bits = vec[chunk_q*SCAN_W +: SCAN_W];
  assign hit  = |bits;
  assign last = (chunk_q == KW'(NChunk - 1));

  // lowest set bit of the current chunk
  always_comb begin
    enc = '0;
    for (int b = SCAN_W - 1; b >= 0; b--) begin
      if (bits[b]) begin
        enc = EW'(b);
      end
    end
  end

  // walk the chunks from the bottom, stop at the first hit or at the last chunk
  always_comb begin
    busy_d  = busy_q;
    chunk_d = chunk_q;
    if (start_i) begin
      busy_d  = 1'b1;
      chunk_d = '0;
    end else if (busy_q) begin
      if (hit || last) begin
        busy_d = 1'b0;
      end else begin
        chunk_d = chunk_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      chunk_q <= '0;
    end else begin
      busy_q  <= busy_d;
      chunk_q <= chunk_d;
    end
  end

  assign stat_o.done = busy_q && (hit || last);
  assign stat_o.hit  = busy_q && hit;
  assign index_o     = IW'({chunk_q, enc});

endmodule

/* src/positional_array_insert_delete_search_top.sv */
// Insert and delete: result goes to the output register, or parked while it is busy;
//   one request per cycle while none is parked. Search: the scan examines eight cells
//   per cycle, bottom up; requests wait until its result is in the output register.
// Results sit in an output register, so a request is taken while a result waits.
// Reset clears the entry count and control state; cell contents are not cleared.
module positional_array_insert_delete_search_top #(
  parameter int unsigned DEPTH = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pai_req_if.sink        req_i,
  pai_res_if.source      res_o
);
  import pai_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 8) ? CW : 8;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   key_q, key_d;
  res_t          pend_q, pend_d;
  res_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          accept, slot_free, scan_start;
  logic [PW-1:0] pos_x, cnt_x;
  logic          full;
  cell_ctrl_t    ctrl;
  res_t          imm_res, scan_res;
  scan_stat_t    scan_stat;
  logic [IW-1:0] scan_idx;

  logic [31:0]      entry_w [DEPTH];
  logic [DEPTH-1:0] match_w;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign slot_free   = !out_valid_q || res_o.ready;
  assign pos_x       = PW'(req_i.position);
  assign cnt_x       = PW'(count_q);
  assign full        = (count_q == CW'(DEPTH));

  // decode the request and build the immediate result
  always_comb begin
    ctrl               = '0;
    count_d            = count_q;
    scan_start         = 1'b0;
    imm_res.status     = STAT_OK;
    imm_res.found      = 1'b0;
    imm_res.found_index = '0;
    if (accept) begin
      unique case (req_i.req_type)
        REQ_INSERT: begin
          if (pos_x > cnt_x) begin
            imm_res.status = STAT_BADPOS;
          end else if (full) begin
            imm_res.status = STAT_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        REQ_DELETE: begin
          if (pos_x >= cnt_x) begin
            imm_res.status = STAT_BADPOS;
          end else begin
            ctrl.del = 1'b1;
            count_d  = count_q - CW'(1);
          end
        end
        REQ_SEARCH: begin
          scan_start = 1'b1;
        end
        default: begin
        end
      endcase
    end
    imm_res.entry_count = 8'(count_d);
  end

  assign key_d = scan_start ? 32'(req_i.value) : key_q;

  assign scan_res.status      = STAT_OK;
  assign scan_res.found       = scan_stat.hit;
  assign scan_res.found_index = scan_stat.hit ? 7'(scan_idx) : 7'd0;
  assign scan_res.entry_count = 8'(count_q);

  // controller: route results to the output register or park them
  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (scan_start) begin
            state_d = S_SCAN;
          end else if (slot_free) begin
            out_d       = imm_res;
            out_valid_d = 1'b1;
          end else begin
            pend_d  = imm_res;
            state_d = S_WAIT;
          end
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          if (slot_free) begin
            out_d       = scan_res;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            pend_d  = scan_res;
            state_d = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // row of entry cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = 32'(req_i.value);
    end else begin : g_mid
      assign left_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = entry_w[i];
    end else begin : g_inner
      assign right_w = entry_w[i+1];
    end
    pai_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_x),
      .cnt_i   (cnt_x),
      .val_i   (32'(req_i.value)),
      .left_i  (left_w),
      .right_i (right_w),
      .key_i   (key_q),
      .entry_o (entry_w[i]),
      .match_o (match_w[i])
    );
  end

  pai_scan #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .match_i (match_w),
    .stat_o  (scan_stat),
    .index_o (scan_idx)
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_q.status;
  assign res_o.found       = out_q.found;
  assign res_o.found_index = out_q.found_index;
  assign res_o.entry_count = out_q.entry_count;

endmodule

/* verif/positional_array_insert_delete_search_top_test.sv */
module positional_array_insert_delete_search_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pai_pkg::*;

  localparam int unsigned DEPTH       = 128;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  // longest search scan plus margin
  localparam int          SETTLE_CYCLES = 40;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk_i;
  logic rst_ni;

  pai_req_if req_bus ();
  pai_res_if res_bus ();

  positional_array_insert_delete_search_top #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  // shadow copy of the list
  logic signed [31:0] list_mem [DEPTH];
  int unsigned        list_cnt;

  res_t pending_res_q [$];
  int   mismatch_cnt;
  int   src_idle_pct;
  int   snk_stall_pct;
  int   sink_hold;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // apply one request to the shadow list, return the result it should give
  function automatic res_t apply_list_op(input logic [1:0] op, input logic [7:0] pos,
                                         input logic signed [31:0] val);
    res_t r;
    int unsigned i;
    r = '0;
    case (op)
      REQ_INSERT: begin
        if (pos > list_cnt) begin
          r.status = STAT_BADPOS;
        end else if (list_cnt >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (i = list_cnt; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_cnt++;
        end
      end
      REQ_DELETE: begin
        if (pos >= list_cnt) begin
          r.status = STAT_BADPOS;
        end else begin
          for (i = pos; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
          list_cnt--;
        end
      end
      REQ_SEARCH: begin
        for (i = 0; i < list_cnt; i++) begin
          if (!r.found && list_mem[i] == val) begin
            r.found       = 1'b1;
            r.found_index = i[6:0];
          end
        end
      end
      default: ;
    endcase
    r.entry_count = list_cnt[7:0];
    return r;
  endfunction

  // one request beat; idles at random first, returns at the accepting edge
  task automatic send_req(input logic [1:0] op, input logic [7:0] pos,
                          input logic signed [31:0] val);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= $urandom_range(0, 3);
      req_bus.position <= $urandom_range(0, 255);
      req_bus.value    <= $urandom;
      @(negedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= op;
    req_bus.position <= pos;
    req_bus.value    <= val;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_res_q.push_back(apply_list_op(op, pos, val));
  endtask

  // drop valid and wait until every pending result is back
  task automatic wait_all_results();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // result receiver: random stalls, plus a counted hold-off on request
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        sink_hold--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_res_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual status %0d count %0d",
                 $time, res_bus.status, res_bus.entry_count);
        mismatch_cnt++;
      end else begin
        want = pending_res_q.pop_front();
        report_field("status", want.status, res_bus.status);
        report_field("found", want.found, res_bus.found);
        report_field("found_index", want.found_index, res_bus.found_index);
        report_field("entry_count", want.entry_count, res_bus.entry_count);
      end
    end
  end

  // random value: wide spread, a small pool for duplicates, and the extremes
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      4, 5, 6: return $signed($urandom_range(0, 15)) - 8;
      7:       return VAL_MIN;
      8:       return VAL_MAX;
      9:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // edges: empty list, bad positions, extremes, duplicates, unused code
  task automatic test_directed();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_req(REQ_DELETE, 8'd0, 0);
    send_req(REQ_INSERT, 8'd1, 0);
    send_req(REQ_SEARCH, 8'd0, 0);
    send_req(REQ_UNUSED, 8'd255, -1);
    send_req(REQ_INSERT, 8'd0, VAL_MIN);
    send_req(REQ_INSERT, 8'd1, VAL_MAX);
    send_req(REQ_INSERT, 8'd0, 5);
    send_req(REQ_INSERT, 8'd3, 5);
    send_req(REQ_INSERT, 8'd255, 7);
    send_req(REQ_INSERT, 8'd5, 7);
    send_req(REQ_SEARCH, 8'd0, VAL_MIN);
    send_req(REQ_SEARCH, 8'd255, VAL_MAX);
    send_req(REQ_SEARCH, 8'd0, 5);
    send_req(REQ_SEARCH, 8'd0, -1);
    send_req(REQ_DELETE, 8'd4, 0);
    send_req(REQ_DELETE, 8'd255, 0);
    send_req(REQ_DELETE, 8'd0, 0);
    send_req(REQ_SEARCH, 8'd0, 5);
    send_req(REQ_DELETE, 8'd2, 0);
    send_req(REQ_UNUSED, 8'd0, 0);
    send_req(REQ_DELETE, 8'd0, 0);
    send_req(REQ_DELETE, 8'd0, 0);
    send_req(REQ_DELETE, 8'd0, 0);
    wait_all_results();
  endtask

  // fill to capacity, poke the full list, then empty it again
  task automatic test_full_list();
    int k;
    src_idle_pct  = 20;
    snk_stall_pct = 20;
    for (k = 0; k < DEPTH; k++) send_req(REQ_INSERT, $urandom_range(0, list_cnt), $urandom);
    send_req(REQ_INSERT, DEPTH, 1);
    send_req(REQ_INSERT, 8'd0, 1);
    send_req(REQ_INSERT, DEPTH + 1, 1);
    send_req(REQ_SEARCH, 8'd0, list_mem[DEPTH-1]);
    send_req(REQ_SEARCH, 8'd0, list_mem[0]);
    send_req(REQ_SEARCH, 8'd0, $urandom);
    while (list_cnt > 0) begin
      send_req(REQ_DELETE, $urandom_range(0, list_cnt - 1), 0);
      if (list_cnt % 8 == 0 && list_cnt > 0)
        send_req(REQ_SEARCH, 8'd0, list_mem[$urandom_range(0, list_cnt - 1)]);
    end
    wait_all_results();
  endtask

  // mostly well-formed traffic that wanders between empty and full
  task automatic test_random_mix(input int src_pct, input int snk_pct, input int n_items);
    logic [1:0]         op;
    logic [7:0]         pos;
    logic signed [31:0] val;
    int unsigned        target;
    int                 roll;
    int                 k;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    target        = 0;
    for (k = 0; k < n_items; k++) begin
      if (k % 60 == 0)
        target = ($urandom_range(0, 3) == 0) ? DEPTH : $urandom_range(0, DEPTH);
      roll = $urandom_range(0, 99);
      val  = pick_value();
      if (roll < 8) begin
        // noise: any code, any position
        op  = $urandom_range(0, 3);
        pos = $urandom_range(0, 255);
      end else if (roll < 38) begin
        op  = REQ_SEARCH;
        pos = $urandom_range(0, 255);
        if (list_cnt > 0 && $urandom_range(0, 2) != 0)
          val = list_mem[$urandom_range(0, list_cnt - 1)];
      end else if (list_cnt == 0 || list_cnt < target ||
                   (list_cnt == target && $urandom_range(0, 1) == 0)) begin
        op  = REQ_INSERT;
        pos = $urandom_range(0, list_cnt);
      end else begin
        op  = REQ_DELETE;
        pos = $urandom_range(0, list_cnt - 1);
      end
      send_req(op, pos, val);
    end
    wait_all_results();
  endtask

  // receiver holds off long while requests keep coming
  task automatic test_stall_fill();
    int k;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    sink_hold     = 400;
    for (k = 0; k < 40; k++) begin
      if (k % 3 == 2) send_req(REQ_SEARCH, 8'd0, pick_value());
      else            send_req(REQ_INSERT, $urandom_range(0, list_cnt), pick_value());
    end
    wait_all_results();
  endtask

  // sender pauses until all results are in, then restarts back to back
  task automatic test_pause_refill();
    int k;
    src_idle_pct  = 0;
    snk_stall_pct = 30;
    for (k = 0; k < 10; k++) send_req(REQ_SEARCH, 8'd0, pick_value());
    wait_all_results();
    for (k = 0; k < 10; k++) begin
      if (list_cnt > 0) send_req(REQ_DELETE, $urandom_range(0, list_cnt - 1), 0);
      else              send_req(REQ_DELETE, 8'd0, 0);
    end
    wait_all_results();
  endtask

  // main sequence
  initial begin
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_INSERT;
    req_bus.position = '0;
    req_bus.value    = '0;
    list_cnt         = 0;
    mismatch_cnt     = 0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    sink_hold        = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_list();
    test_random_mix(0, 0, 280);
    test_random_mix(72, 0, 280);
    test_random_mix(0, 72, 280);
    test_random_mix(7, 7, 280);
    test_stall_fill();
    test_pause_refill();

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_res_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* positional_array_insert_delete_search_top.f */
src/pai_pkg.sv
src/pai_req_if.sv
src/pai_res_if.sv
src/pai_cell.sv
src/pai_scan.sv
src/positional_array_insert_delete_search_top.sv
verif/positional_array_insert_delete_search_top_test.sv
